@@ sv/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// Types, codes and sizes shared by the keyframe track sampler modules.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] KIND_CONSTANT    = 3'd0;
    localparam logic [2:0] KIND_LINEAR      = 3'd1;
    localparam logic [2:0] KIND_SPLINE_ZERO = 3'd2;
    localparam logic [2:0] KIND_SPLINE      = 3'd3;
    localparam logic [2:0] KIND_SLOPE       = 3'd4;
    localparam logic [2:0] KIND_KEY         = 3'd5;
    localparam logic [2:0] KIND_BAD         = 3'd7;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BADKIND = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         key_kind;
        logic signed [31:0] key_frame;
        logic signed [31:0] key_value;
        logic signed [31:0] key_tangent;
        logic signed [31:0] query_frame;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame;
        logic [31:0] value;
        logic [31:0] tangent;
    } t_key;

    typedef enum logic [0:0] {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

endpackage

@@ sv/kts_keymem.sv @@
// ----------------------------------------------------------------------------
// kts_keymem
// Key table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kts_keymem
    import kts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [KEY_AW-1:0] i_waddr,
    input  t_key              i_wdata,
    input  logic [KEY_AW-1:0] i_raddr,
    output t_key              o_rdata
);

    t_key r_mem [MAX_KEYS];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/kts_alu.sv @@
// ----------------------------------------------------------------------------
// kts_alu
// Shared serial unit: shift-add multiply (64-bit wrapped product, stops when
// the multiplier runs out of ones) and 64 by 33 bit restoring divide.
// ----------------------------------------------------------------------------
module kts_alu
    import kts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_res,
    output logic        o_done
);

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [5:0]  r_cnt;

    logic [33:0] div_t;
    logic [33:0] div_d;
    logic        div_ge;
    logic [33:0] div_r;

    assign div_t  = {r_acc[32:0], r_a[63]};
    assign div_d  = {1'b0, r_b[32:0]};
    assign div_ge = (div_t >= div_d);
    assign div_r  = div_t - div_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_op == ALU_MUL) begin
                    if (r_b == 64'd0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_op  <= i_req.op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= 64'd0;
            r_cnt <= 6'd0;
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                if (r_b != 64'd0) begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= {r_a[62:0], 1'b0};
                    r_b <= {1'b0, r_b[63:1]};
                end
            end else begin
                // quotient bits shift into the dividend register
                r_acc <= {31'd0, div_ge ? div_r[32:0] : div_t[32:0]};
                r_a   <= {r_a[62:0], div_ge};
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    assign o_res  = (r_op == ALU_DIV) ? r_a : r_acc;
    assign o_done = r_done;

endmodule

@@ sv/keyframe_track_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_track_sampler_unit
// Animation track store and cubic Hermite / linear keyframe sampler, Q16.16.
// ----------------------------------------------------------------------------
// Usage: items enter on i_in_valid / o_in_stall, results leave on
// o_out_valid / i_out_stall; every input beat gives exactly one result beat.
// Clear, append, unknown opcodes and a sample of an empty track go straight
// to the output stage; a sample that hits the last key early returns that
// key's value. Otherwise the walk reads the keys in turn, followed by one
// segment check and, where the segment interpolates, the shared serial unit.
// Linear segments use one multiply and one divide; Hermite segments one
// divide and eight multiplies. The result then goes to the output register.
// One item is worked at a time: o_in_stall is high from accept until the
// result is handed to the output register. That register holds a result
// while i_out_stall is high, and the next item may be accepted meanwhile.
// The user must write the frame offset via i_cfg_we only while idle; the
// block itself does not enforce this. Reset empties the track and clears
// the offset; key storage is not cleared.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_unit
    import kts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LRD  = 9'b000000010,
        S_LCHK = 9'b000000100,
        S_WRD  = 9'b000001000,
        S_WCHK = 9'b000010000,
        S_EVAL = 9'b000100000,
        S_GO   = 9'b001000000,
        S_WAIT = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [10:0] {
        ST_LMUL = 11'b00000000001,
        ST_LDIV = 11'b00000000010,
        ST_HDIV = 11'b00000000100,
        ST_S2   = 11'b00000001000,
        ST_S3   = 11'b00000010000,
        ST_DD0  = 11'b00000100000,
        ST_DD1  = 11'b00001000000,
        ST_T0   = 11'b00010000000,
        ST_T1   = 11'b00100000000,
        ST_T2   = 11'b01000000000,
        ST_T3   = 11'b10000000000
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic [KEY_AW-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_nkeys, n_nkeys;
    logic [15:0]       r_start;
    logic [2:0]        r_prev, n_prev;
    logic signed [31:0] r_f, n_f, r_t0, n_t0, r_t1, n_t1;
    logic signed [31:0] r_p0, n_p0, r_p1, n_p1, r_d0, n_d0, r_d1, n_d1;
    logic [32:0]  r_dt, n_dt, r_df, n_df;
    logic [63:0]  r_m, n_m, r_acc, n_acc;
    logic [16:0]  r_s, n_s, r_s2, n_s2, r_s3, n_s3;
    logic signed [48:0] r_dd0, n_dd0, r_dd1, n_dd1;
    t_out r_res, n_res;
    t_out r_out;
    logic r_ovalid;

    logic in_acc, out_free, push;
    logic mem_we;
    t_key wkey, rkey;

    t_alu_req    alu_req;
    logic [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;
    logic        mul_neg;

    logic signed [33:0] f_sum;
    logic signed [31:0] f_sat;
    logic signed [32:0] dp;
    logic [32:0]        dp_mag;
    logic signed [19:0] hs, hs2, hs3, h00, h10, h01, h11;
    logic [19:0]        m00, m10, m01, m11;
    logic [31:0]        p0_mag, p1_mag, d0_mag, d1_mag;
    logic [48:0]        dd0_mag, dd1_mag;
    logic [63:0]        rnd, sv, acc_sum;
    logic signed [31:0] acc_sat;

    logic signed [31:0] w_t0, w_t1, w_p0, w_p1, w_d0, w_d1;
    logic               w_bad;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign push     = (r_state == S_OUT) && out_free;
    assign o_in_stall = (r_state != S_IDLE);

    assign wkey = '{kind: i_in_data.key_kind, frame: i_in_data.key_frame,
                    value: i_in_data.key_value, tangent: i_in_data.key_tangent};

    kts_keymem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_nkeys[KEY_AW-1:0]),
        .i_wdata (wkey),
        .i_raddr (r_idx),
        .o_rdata (rkey)
    );

    kts_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_done  (alu_done)
    );

    // sampled frame, offset by whole frames and saturated
    assign f_sum = {{2{i_in_data.query_frame[31]}}, i_in_data.query_frame}
                 + $signed({2'b00, r_start, 16'h0000});
    assign f_sat = (f_sum[33:31] == 3'b000 || f_sum[33:31] == 3'b111) ? f_sum[31:0]
                 : (f_sum[33] ? 32'sh80000000 : 32'sh7fffffff);

    assign dp     = {r_p1[31], r_p1} - {r_p0[31], r_p0};
    assign dp_mag = dp[32] ? 33'(-dp) : 33'(dp);

    // Hermite basis, Q16
    assign hs  = {3'b000, r_s};
    assign hs2 = {3'b000, r_s2};
    assign hs3 = {3'b000, r_s3};
    assign h00 = (hs3 <<< 1) - (hs2 + (hs2 <<< 1)) + 20'sd65536;
    assign h10 = hs3 - (hs2 <<< 1) + hs;
    assign h01 = (hs2 + (hs2 <<< 1)) - (hs3 <<< 1);
    assign h11 = hs3 - hs2;
    assign m00 = h00[19] ? 20'(-h00) : 20'(h00);
    assign m10 = h10[19] ? 20'(-h10) : 20'(h10);
    assign m01 = h01[19] ? 20'(-h01) : 20'(h01);
    assign m11 = h11[19] ? 20'(-h11) : 20'(h11);
    assign p0_mag  = r_p0[31] ? 32'(-r_p0) : 32'(r_p0);
    assign p1_mag  = r_p1[31] ? 32'(-r_p1) : 32'(r_p1);
    assign d0_mag  = r_d0[31] ? 32'(-r_d0) : 32'(r_d0);
    assign d1_mag  = r_d1[31] ? 32'(-r_d1) : 32'(r_d1);
    assign dd0_mag = r_dd0[48] ? 49'(-r_dd0) : 49'(r_dd0);
    assign dd1_mag = r_dd1[48] ? 49'(-r_dd1) : 49'(r_dd1);

    always_comb begin
        alu_req.go = (r_state == S_GO);
        alu_req.op = ALU_MUL;
        alu_a      = 64'd0;
        alu_b      = 64'd0;
        mul_neg    = 1'b0;
        case (r_step)
            ST_LMUL: begin
                alu_a = {31'd0, dp_mag};
                alu_b = {31'd0, r_df};
            end
            ST_LDIV: begin
                alu_req.op = ALU_DIV;
                alu_a = r_m + {32'd0, r_dt[32:1]};
                alu_b = {31'd0, r_dt};
            end
            ST_HDIV: begin
                alu_req.op = ALU_DIV;
                alu_a = {15'd0, r_df, 16'h0000} + {32'd0, r_dt[32:1]};
                alu_b = {31'd0, r_dt};
            end
            ST_S2: begin
                alu_a = {47'd0, r_s};
                alu_b = {47'd0, r_s};
            end
            ST_S3: begin
                alu_a = {47'd0, r_s2};
                alu_b = {47'd0, r_s};
            end
            ST_DD0: begin
                alu_a   = {31'd0, r_dt};
                alu_b   = {32'd0, d0_mag};
                mul_neg = r_d0[31];
            end
            ST_DD1: begin
                alu_a   = {31'd0, r_dt};
                alu_b   = {32'd0, d1_mag};
                mul_neg = r_d1[31];
            end
            ST_T0: begin
                alu_a   = {32'd0, p0_mag};
                alu_b   = {44'd0, m00};
                mul_neg = r_p0[31] ^ h00[19];
            end
            ST_T1: begin
                alu_a   = {15'd0, dd0_mag};
                alu_b   = {44'd0, m10};
                mul_neg = r_dd0[48] ^ h10[19];
            end
            ST_T2: begin
                alu_a   = {32'd0, p1_mag};
                alu_b   = {44'd0, m01};
                mul_neg = r_p1[31] ^ h01[19];
            end
            ST_T3: begin
                alu_a   = {15'd0, dd1_mag};
                alu_b   = {44'd0, m11};
                mul_neg = r_dd1[48] ^ h11[19];
            end
            default: begin
                alu_req.go = 1'b0;
            end
        endcase
    end

    // rounding Q16 product, signed
    assign rnd     = alu_res + 64'd32768;
    assign sv      = mul_neg ? (64'd0 - {16'd0, rnd[63:16]}) : {16'd0, rnd[63:16]};
    assign acc_sum = r_acc + sv;
    assign acc_sat = (acc_sum[63:31] == {33{acc_sum[63]}}) ? acc_sum[31:0]
                   : (acc_sum[63] ? 32'sh80000000 : 32'sh7fffffff);

    // segment update for one walked key
    always_comb begin
        w_t0  = r_t0;
        w_t1  = r_t1;
        w_p0  = r_p0;
        w_p1  = r_p1;
        w_d0  = r_d0;
        w_d1  = r_d1;
        w_bad = 1'b0;
        case (rkey.kind)
            KIND_CONSTANT, KIND_LINEAR: begin
                w_p0 = r_p1;
                w_p1 = rkey.value;
                if (r_prev != KIND_SLOPE) begin
                    w_d0 = r_d1;
                    w_d1 = 32'sd0;
                end
                w_t0 = r_t1;
                w_t1 = rkey.frame;
            end
            KIND_SPLINE_ZERO: begin
                w_p0 = r_p1;
                w_d0 = r_d1;
                w_p1 = rkey.value;
                w_d1 = 32'sd0;
                w_t0 = r_t1;
                w_t1 = rkey.frame;
            end
            KIND_SPLINE: begin
                w_p0 = r_p1;
                w_p1 = rkey.value;
                w_d0 = r_d1;
                w_d1 = rkey.tangent;
                w_t0 = r_t1;
                w_t1 = rkey.frame;
            end
            KIND_SLOPE: begin
                w_d0 = r_d1;
                w_d1 = rkey.tangent;
            end
            KIND_KEY: begin
                w_p0 = rkey.value;
                w_p1 = rkey.value;
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_nkeys = r_nkeys;
        n_prev  = r_prev;
        n_f     = r_f;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_dt    = r_dt;
        n_df    = r_df;
        n_m     = r_m;
        n_acc   = r_acc;
        n_s     = r_s;
        n_s2    = r_s2;
        n_s3    = r_s3;
        n_dd0   = r_dd0;
        n_dd1   = r_dd1;
        n_res   = r_res;
        mem_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '{sample_value: 32'sd0, status: STAT_OK};
                    n_state = S_OUT;
                    unique case (i_in_data.opcode)
                        OP_CLEAR: begin
                            n_nkeys = '0;
                        end
                        OP_APPEND: begin
                            if (r_nkeys == CNT_W'(MAX_KEYS)) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_nkeys = r_nkeys + CNT_W'(1);
                            end
                        end
                        OP_SAMPLE: begin
                            n_f    = f_sat;
                            n_prev = KIND_CONSTANT;
                            n_t0   = 32'sd0;
                            n_t1   = 32'sd0;
                            n_p0   = 32'sd0;
                            n_p1   = 32'sd0;
                            n_d0   = 32'sd0;
                            n_d1   = 32'sd0;
                            if (r_nkeys != '0) begin
                                n_idx   = KEY_AW'(r_nkeys - CNT_W'(1));
                                n_state = S_LRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LRD: begin
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (r_nkeys > CNT_W'(1) && r_f >= $signed(rkey.frame)) begin
                    n_res.sample_value = rkey.value;
                    n_state = S_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (w_bad) begin
                    n_res.status = STAT_BADKIND;
                    n_state = S_OUT;
                end else begin
                    n_t0 = w_t0;
                    n_t1 = w_t1;
                    n_p0 = w_p0;
                    n_p1 = w_p1;
                    n_d0 = w_d0;
                    n_d1 = w_d1;
                    if (w_t1 > r_f && rkey.kind != KIND_SLOPE) begin
                        // segment found; prev keeps the kind before this key
                        n_state = S_EVAL;
                    end else begin
                        n_prev = rkey.kind;
                        if ({1'b0, r_idx} == CNT_W'(r_nkeys - CNT_W'(1))) begin
                            n_state = S_EVAL;
                        end else begin
                            n_idx   = r_idx + KEY_AW'(1);
                            n_state = S_WRD;
                        end
                    end
                end
            end
            S_EVAL: begin
                n_dt  = {r_t1[31], r_t1} - {r_t0[31], r_t0};
                n_df  = {r_f[31], r_f} - {r_t0[31], r_t0};
                n_acc = 64'd0;
                if (r_f <= r_t0) begin
                    n_res.sample_value = r_p0;
                    n_state = S_OUT;
                end else if (r_f >= r_t1) begin
                    n_res.sample_value = r_p1;
                    n_state = S_OUT;
                end else if (r_t0 == r_t1 || r_prev == KIND_CONSTANT
                             || r_prev == KIND_KEY) begin
                    n_res.sample_value = r_p0;
                    n_state = S_OUT;
                end else begin
                    n_step  = (r_prev == KIND_LINEAR) ? ST_LMUL : ST_HDIV;
                    n_state = S_GO;
                end
            end
            S_GO: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (alu_done) begin
                    n_state = S_GO;
                    case (r_step)
                        ST_LMUL: begin
                            n_m    = alu_res;
                            n_step = ST_LDIV;
                        end
                        ST_LDIV: begin
                            n_res.sample_value = dp[32] ? (r_p0 - $signed(alu_res[31:0]))
                                                        : (r_p0 + $signed(alu_res[31:0]));
                            n_state = S_OUT;
                        end
                        ST_HDIV: begin
                            n_s    = alu_res[16:0];
                            n_step = ST_S2;
                        end
                        ST_S2: begin
                            n_s2   = rnd[32:16];
                            n_step = ST_S3;
                        end
                        ST_S3: begin
                            n_s3   = rnd[32:16];
                            n_step = ST_DD0;
                        end
                        ST_DD0: begin
                            n_dd0  = sv[48:0];
                            n_step = ST_DD1;
                        end
                        ST_DD1: begin
                            n_dd1  = sv[48:0];
                            n_step = ST_T0;
                        end
                        ST_T0: begin
                            n_acc  = acc_sum;
                            n_step = ST_T1;
                        end
                        ST_T1: begin
                            n_acc  = acc_sum;
                            n_step = ST_T2;
                        end
                        ST_T2: begin
                            n_acc  = acc_sum;
                            n_step = ST_T3;
                        end
                        ST_T3: begin
                            n_res.sample_value = acc_sat;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nkeys  <= '0;
            r_start  <= 16'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nkeys <= n_nkeys;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_idx  <= n_idx;
        r_prev <= n_prev;
        r_f    <= n_f;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_d0   <= n_d0;
        r_d1   <= n_d1;
        r_dt   <= n_dt;
        r_df   <= n_df;
        r_m    <= n_m;
        r_acc  <= n_acc;
        r_s    <= n_s;
        r_s2   <= n_s2;
        r_s3   <= n_s3;
        r_dd0  <= n_dd0;
        r_dd1  <= n_dd1;
        r_res  <= n_res;
        if (push) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_nkeys_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nkeys <= CNT_W'(MAX_KEYS))
        else $error("key count beyond table depth");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside wait state");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.opcode == OP_CLEAR) |=> (r_nkeys == '0))
        else $error("clear did not empty the track");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("result beat lost at output register");

endmodule
